/* rtl/srp_pkg.sv */
// shared types, field widths, codes and helper functions of the shelf rectangle packer
// no dependencies; imported by every module of the block except srp_ram
package srp_pkg;

    // fixed packing constants
    localparam int GAP_PIXELS       = 1;
    localparam int MAX_SIDE_LOG2    = 13;
    localparam int UV_FRACTION_BITS = 16;
    localparam int ROOM_ROWS        = 32;

    // field widths
    localparam int MODE_W   = 2;
    localparam int DIM_W    = 14;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 13;
    localparam int UV_W     = 17;
    localparam int SIDE_W   = 14;
    localparam int LOG2_W   = 4;
    localparam int USED_W   = 27;
    localparam int PAD_W    = 15;
    localparam int SUM_W    = 16;
    localparam int PROD_W   = 2 * DIM_W;
    localparam int FULL_W   = 32;

    localparam logic [LOG2_W-1:0] INIT_LOG2_RESET = 4'd10;
    localparam logic [USED_W-1:0] USED_MAX        = {USED_W{1'b1}};

    // item modes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GROW   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REINIT = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_WIDE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_GROW_REFUSED = 3'd5;

    // one shelf table entry
    typedef struct packed {
        logic [POS_W-1:0] top;
        logic [DIM_W-1:0] tall;
        logic [DIM_W-1:0] fill;
    } shelf_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic open_shelf;
        logic accum;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic alloc_go;
        logic have_shelves;
        logic hit;
        logic scan_last;
        logic new_ok;
        logic out_free;
    } stat_t;

    function automatic logic [SIDE_W-1:0] side_of(input logic [LOG2_W-1:0] lg);
        return SIDE_W'(1) << lg;
    endfunction

    // pixel coordinate to fixed-point texture coordinate, truncated
    function automatic logic [UV_W-1:0] to_uv(input logic [PAD_W-1:0] pix,
                                             input logic [LOG2_W-1:0] lg);
        logic [PAD_W+UV_FRACTION_BITS-1:0] wide;
        wide = {pix, {UV_FRACTION_BITS{1'b0}}} >> lg;
        return wide[UV_W-1:0];
    endfunction

endpackage

/* rtl/srp_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/srp_datapath.sv */
// datapath of the shelf rectangle packer: packer state, shelf table, result register
// depends on srp_pkg and srp_ram
module srp_datapath import srp_pkg::*; #(
    parameter int SHELF_SLOTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                cfg_we,
    input  logic [LOG2_W-1:0]   cfg_data,
    input  logic [MODE_W-1:0]   mode,
    input  logic [DIM_W-1:0]    rect_width,
    input  logic [DIM_W-1:0]    rect_height,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    output logic [UV_W-1:0]     u_left,
    output logic [UV_W-1:0]     v_top,
    output logic [UV_W-1:0]     u_right,
    output logic [UV_W-1:0]     v_bottom,
    output logic                nearly_full,
    output logic [SIDE_W-1:0]   side_now
);

    localparam int IDX_W = (SHELF_SLOTS > 1) ? $clog2(SHELF_SLOTS) : 1;
    localparam int CNT_W = $clog2(SHELF_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SHELF_SLOTS);
    localparam int ACC_W = PROD_W + 1;

    // control state
    logic [LOG2_W-1:0]   init_log2_reg;
    logic [LOG2_W-1:0]   side_log2_reg;
    logic [CNT_W-1:0]    shelves_used_reg;
    logic [SIDE_W-1:0]   next_row_reg;
    logic [USED_W-1:0]   used_reg;
    logic                out_valid_reg;

    // item payload
    logic [MODE_W-1:0]   mode_reg;
    logic [DIM_W-1:0]    w_reg;
    logic [DIM_W-1:0]    h_reg;
    logic [PROD_W-1:0]   product_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [POS_W-1:0]    px_reg;
    logic [POS_W-1:0]    py_reg;
    logic                placed_reg;
    logic [STATUS_W-1:0] item_status_reg;

    // result register
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    pos_x_reg;
    logic [POS_W-1:0]    pos_y_reg;
    logic [UV_W-1:0]     u_left_reg;
    logic [UV_W-1:0]     v_top_reg;
    logic [UV_W-1:0]     u_right_reg;
    logic [UV_W-1:0]     v_bottom_reg;
    logic                nearly_full_reg;
    logic [SIDE_W-1:0]   side_now_reg;

    logic [SIDE_W-1:0]   side;
    logic [PAD_W-1:0]    pw;
    logic [PAD_W-1:0]    ph;
    logic                size_zero;
    logic                too_wide;
    logic                grow_ok;
    logic [LOG2_W-1:0]   init_clamped;
    shelf_t              rd_shelf;
    shelf_t              wr_shelf;
    logic [SUM_W-1:0]    fill_sum;
    logic [SUM_W-1:0]    row_sum;
    logic                hit;
    logic                no_room;
    logic                table_full;
    logic                new_ok;
    logic [CNT_W-1:0]    scan_next;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_en;
    logic [ACC_W-1:0]    acc_sum;
    logic [FULL_W-1:0]   used_x10;
    logic [FULL_W-1:0]   total_x9;
    logic                full_now;
    logic                out_free;

    assign side         = side_of(side_log2_reg);
    assign pw           = PAD_W'(w_reg) + PAD_W'(GAP_PIXELS);
    assign ph           = PAD_W'(h_reg) + PAD_W'(GAP_PIXELS);
    assign size_zero    = (w_reg == '0) || (h_reg == '0);
    assign too_wide     = PAD_W'(w_reg) > PAD_W'(side);
    assign grow_ok      = (5'(side_log2_reg) + 5'd1) <= 5'(MAX_SIDE_LOG2);
    assign init_clamped = (init_log2_reg > LOG2_W'(MAX_SIDE_LOG2)) ?
                          LOG2_W'(MAX_SIDE_LOG2) : init_log2_reg;

    // first-fit test on the entry read last cycle
    assign fill_sum   = SUM_W'(rd_shelf.fill) + SUM_W'(pw);
    assign hit        = (SUM_W'(rd_shelf.tall) >= SUM_W'(ph)) && (fill_sum <= SUM_W'(side));
    assign row_sum    = SUM_W'(next_row_reg) + SUM_W'(ph);
    assign no_room    = row_sum > SUM_W'(side);
    assign table_full = shelves_used_reg >= SLOTS_C;
    assign new_ok     = !no_room && !table_full;
    assign scan_next  = CNT_W'(scan_idx_reg) + CNT_W'(1);

    // read ahead one entry while the current one is tested
    assign rd_addr = cmd.scan ? IDX_W'(scan_next) : '0;
    assign wr_en   = (cmd.scan && hit) || (cmd.open_shelf && new_ok);
    assign wr_addr = cmd.scan ? scan_idx_reg : shelves_used_reg[IDX_W-1:0];

    always_comb
    begin
        if (cmd.scan)
        begin
            wr_shelf.top  = rd_shelf.top;
            wr_shelf.tall = rd_shelf.tall;
            wr_shelf.fill = fill_sum[DIM_W-1:0];
        end
        else
        begin
            wr_shelf.top  = next_row_reg[POS_W-1:0];
            wr_shelf.tall = ph[DIM_W-1:0];
            wr_shelf.fill = pw[DIM_W-1:0];
        end
    end

    srp_ram #(
        .WIDTH ($bits(shelf_t)),
        .DEPTH (SHELF_SLOTS)
    ) u_shelf_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_shelf),
        .rd_addr (rd_addr),
        .rd_data (rd_shelf)
    );

    assign acc_sum  = ACC_W'(used_reg) + ACC_W'(product_reg);
    assign used_x10 = (FULL_W'(used_reg) << 3) + (FULL_W'(used_reg) << 1);
    assign total_x9 = FULL_W'(9) << {side_log2_reg, 1'b0};
    assign full_now = (used_x10 > total_x9) ||
                      ((SUM_W'(next_row_reg) + SUM_W'(ROOM_ROWS)) >= SUM_W'(side));
    assign out_free = !out_valid_reg || !out_stall;

    assign stat.alloc_go     = (mode_reg == MODE_ALLOC) && !size_zero && !too_wide;
    assign stat.have_shelves = shelves_used_reg != '0;
    assign stat.hit          = hit;
    assign stat.scan_last    = scan_next == shelves_used_reg;
    assign stat.new_ok       = new_ok;
    assign stat.out_free     = out_free;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_log2_reg    <= INIT_LOG2_RESET;
            side_log2_reg    <= INIT_LOG2_RESET;
            shelves_used_reg <= '0;
            next_row_reg     <= '0;
            used_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                init_log2_reg <= cfg_data;
            end
            if (cmd.decode)
            begin
                case (mode_reg)
                    MODE_CLEAR:
                    begin
                        shelves_used_reg <= '0;
                        next_row_reg     <= '0;
                        used_reg         <= '0;
                    end
                    MODE_GROW:
                    begin
                        if (grow_ok)
                        begin
                            side_log2_reg    <= side_log2_reg + LOG2_W'(1);
                            shelves_used_reg <= '0;
                            next_row_reg     <= '0;
                            used_reg         <= '0;
                        end
                    end
                    MODE_REINIT:
                    begin
                        side_log2_reg    <= init_clamped;
                        shelves_used_reg <= '0;
                        next_row_reg     <= '0;
                        used_reg         <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.open_shelf && new_ok)
            begin
                shelves_used_reg <= shelves_used_reg + CNT_W'(1);
                next_row_reg     <= row_sum[SIDE_W-1:0];
            end
            if (cmd.accum)
            begin
                used_reg <= (acc_sum > ACC_W'(USED_MAX)) ? USED_MAX : acc_sum[USED_W-1:0];
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            w_reg    <= rect_width;
            h_reg    <= rect_height;
        end
        if (cmd.decode)
        begin
            product_reg  <= PROD_W'(w_reg) * PROD_W'(h_reg);
            scan_idx_reg <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            placed_reg   <= 1'b0;
            case (mode_reg)
                MODE_CLEAR:  item_status_reg <= ST_OK;
                MODE_REINIT: item_status_reg <= ST_OK;
                MODE_GROW:   item_status_reg <= grow_ok ? ST_OK : ST_GROW_REFUSED;
                default:
                begin
                    if (size_zero)
                    begin
                        item_status_reg <= ST_ZERO_SIZE;
                    end
                    else if (too_wide)
                    begin
                        item_status_reg <= ST_TOO_WIDE;
                    end
                    else
                    begin
                        item_status_reg <= ST_OK;
                    end
                end
            endcase
        end
        if (cmd.scan)
        begin
            if (hit)
            begin
                px_reg     <= rd_shelf.fill[POS_W-1:0];
                py_reg     <= rd_shelf.top;
                placed_reg <= 1'b1;
            end
            else
            begin
                scan_idx_reg <= scan_next[IDX_W-1:0];
            end
        end
        if (cmd.open_shelf)
        begin
            if (no_room)
            begin
                item_status_reg <= ST_NO_ROOM;
            end
            else if (table_full)
            begin
                item_status_reg <= ST_TABLE_FULL;
            end
            else
            begin
                px_reg     <= '0;
                py_reg     <= next_row_reg[POS_W-1:0];
                placed_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            status_reg      <= item_status_reg;
            pos_x_reg       <= placed_reg ? px_reg : '0;
            pos_y_reg       <= placed_reg ? py_reg : '0;
            u_left_reg      <= placed_reg ? to_uv(PAD_W'(px_reg), side_log2_reg) : '0;
            v_top_reg       <= placed_reg ? to_uv(PAD_W'(py_reg), side_log2_reg) : '0;
            u_right_reg     <= placed_reg ?
                               to_uv(PAD_W'(px_reg) + PAD_W'(w_reg), side_log2_reg) : '0;
            v_bottom_reg    <= placed_reg ?
                               to_uv(PAD_W'(py_reg) + PAD_W'(h_reg), side_log2_reg) : '0;
            nearly_full_reg <= full_now;
            side_now_reg    <= side;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign u_left      = u_left_reg;
    assign v_top       = v_top_reg;
    assign u_right     = u_right_reg;
    assign v_bottom    = v_bottom_reg;
    assign nearly_full = nearly_full_reg;
    assign side_now    = side_now_reg;

endmodule

/* rtl/srp_ctrl.sv */
// controller state machine of the shelf rectangle packer
// depends on srp_pkg for the command and status structs
module srp_ctrl import srp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_NEW    = 3'd3;
    localparam logic [2:0] S_ACCUM  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (!stat.alloc_go)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.have_shelves)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_ACCUM;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_NEW;
                end
            end
            S_NEW:
            begin
                cmd.open_shelf = 1'b1;
                state_next     = stat.new_ok ? S_ACCUM : S_FINISH;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

/* rtl/shelf_rect_packer_unit.sv */
// top level of the shelf rectangle packer: controller, datapath and config port
// depends on srp_pkg, srp_ctrl, srp_datapath and srp_ram
//
// Packs rectangles into a square power-of-two atlas with first-fit shelves, one
// result transaction per input transaction. Items are handled one at a time. Clear,
// grow, reinitialize and allocate requests rejected for size go from decode straight
// to the result load; an allocate scans the shelf table, opens a new shelf when no
// shelf fits, updates the usage when placed and then loads the result. The first-fit
// scan reads one shelf entry a cycle from the single-read shelf memory. A finished
// result waits in an output register while the next transaction is accepted; if
// that result is still waiting when the next one is done, the next one holds in its
// last cycle until the output register frees up. The shelf memory has no clearing
// pass: only entries below the shelf count are read, and each of those was written
// by the allocate that opened it. The configuration port takes a write at any
// cycle (cfg_ready is always high); the new initial side takes effect at the next
// reinitialize.
module shelf_rect_packer_unit import srp_pkg::*; #(
    parameter int SHELF_SLOTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,

    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LOG2_W-1:0]   cfg_data,

    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [DIM_W-1:0]    rect_width,
    input  logic [DIM_W-1:0]    rect_height,

    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    output logic [UV_W-1:0]     u_left,
    output logic [UV_W-1:0]     v_top,
    output logic [UV_W-1:0]     u_right,
    output logic [UV_W-1:0]     v_bottom,
    output logic                nearly_full,
    output logic [SIDE_W-1:0]   side_now
);

    cmd_t  cmd;
    stat_t stat;

    // the user must issue register writes only while the block is idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencing: decode, shelf scan, new shelf, usage update, result load
    srp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // packer state, shelf memory and result register
    srp_datapath #(
        .SHELF_SLOTS (SHELF_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .u_left      (u_left),
        .v_top       (v_top),
        .u_right     (u_right),
        .v_bottom    (v_bottom),
        .nearly_full (nearly_full),
        .side_now    (side_now)
    );

endmodule

/* rtl/srp_checker.sv */
// port-level checker of the shelf rectangle packer, bound to the top level
// depends on srp_pkg and on the ports of shelf_rect_packer_unit
module srp_checker import srp_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [POS_W-1:0]    pos_x,
    input logic [POS_W-1:0]    pos_y,
    input logic [UV_W-1:0]     u_left,
    input logic [UV_W-1:0]     v_top,
    input logic [UV_W-1:0]     u_right,
    input logic [UV_W-1:0]     v_bottom,
    input logic [SIDE_W-1:0]   side_now
);

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a transaction is in progress");

    // stalled result stays offered
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(status) && $stable(pos_x) &&
                                      $stable(pos_y) && $stable(side_now)))
        else $error("result payload changed while stalled");

    // atlas side is always a power of two
    a_side_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(side_now))
        else $error("side_now is not a power of two");

    // failed transactions carry no placement
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((pos_x == '0) && (pos_y == '0) &&
            (u_left == '0) && (v_top == '0) && (u_right == '0) && (v_bottom == '0)))
        else $error("placement reported on a failed transaction");

endmodule

bind shelf_rect_packer_unit srp_checker u_srp_checker (.*);
